// ===== design/ffsot_pkg.sv =====
// Shared types, constants and helper functions for the first-free-slot owner table.
`timescale 1ns / 1ps

package ffsot_pkg;

    localparam int SLOTS    = 1024;
    localparam int ROW_W    = 32;
    localparam int ROWS     = SLOTS / ROW_W;
    localparam int BIT_AW   = $clog2(ROW_W);
    localparam int ROW_AW   = $clog2(ROWS);
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = 11;
    localparam int PID_W    = 31;
    localparam int NUM_W    = 16;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 3;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] SEAT_COUNT_RESET = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_CLOSED = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADID  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADNUM = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd5;

    localparam logic REG_ROOM_OPEN  = 1'b0;
    localparam logic REG_SEAT_COUNT = 1'b1;

    typedef struct packed {
        logic capture;
        logic look;
        logic commit;
    } ffsot_cmd_t;

    // Index of the lowest clear bit of a busy row; zero when the row is full.
    function automatic logic [BIT_AW-1:0] first_zero_bit(input logic [ROW_W-1:0] row);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (!row[i])
            begin
                idx = BIT_AW'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest row that still has an empty slot.
    function automatic logic [ROW_AW-1:0] first_open_row(input logic [ROWS-1:0] full);
        logic [ROW_AW-1:0] idx;
        idx = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (!full[i])
            begin
                idx = ROW_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/ffsot_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ffsot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffsot_ctrl.sv =====
// Controller state machine that sequences capture, table lookup and commit of each word.
`timescale 1ns / 1ps

module ffsot_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ffsot_pkg::ffsot_cmd_t ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        ctl.capture = (state_reg == S_IDLE) && in_valid;
        ctl.look    = (state_reg == S_LOOK);
        ctl.commit  = (state_reg == S_EVAL) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (ctl.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/ffsot_dp.sv =====
// Datapath holding the busy and owner memories, row summaries, count and result word.
`timescale 1ns / 1ps

module ffsot_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ffsot_pkg::ffsot_cmd_t               ctl,
    input  logic                                clr,
    input  logic                                room_open,
    input  logic [ffsot_pkg::CNT_W-1:0]         used,
    input  logic [ffsot_pkg::CMD_W-1:0]         cmd,
    input  logic [ffsot_pkg::PID_W-1:0]         person_id,
    input  logic [ffsot_pkg::NUM_W-1:0]         seat_number,
    output logic [ffsot_pkg::STAT_W-1:0]        status,
    output logic [ffsot_pkg::CNT_W-1:0]         seat_given,
    output logic [ffsot_pkg::PID_W-1:0]         owner_id,
    output logic [ffsot_pkg::CNT_W-1:0]         free_count,
    output logic [ffsot_pkg::CNT_W-1:0]         occupied_count
);

    logic [ffsot_pkg::CMD_W-1:0]  cmd_reg;
    logic [ffsot_pkg::PID_W-1:0]  pid_reg;
    logic [ffsot_pkg::NUM_W-1:0]  num_reg;
    logic [ffsot_pkg::ROW_AW-1:0] row_reg;
    logic [ffsot_pkg::BIT_AW-1:0] bit_reg;
    logic                         nofree_reg;
    logic                         numbad_reg;
    logic [ffsot_pkg::ROWS-1:0]   row_valid_reg;
    logic [ffsot_pkg::ROWS-1:0]   row_full_reg;
    logic [ffsot_pkg::CNT_W-1:0]  busy_total_reg;

    logic [ffsot_pkg::STAT_W-1:0] status_reg;
    logic [ffsot_pkg::CNT_W-1:0]  given_reg;
    logic [ffsot_pkg::PID_W-1:0]  owner_reg;
    logic [ffsot_pkg::CNT_W-1:0]  free_reg;
    logic [ffsot_pkg::CNT_W-1:0]  occ_reg;

    logic [ffsot_pkg::NUM_W-1:0]  num_m1;
    logic [ffsot_pkg::IDX_W-1:0]  look_idx;
    logic                         is_reserve;
    logic                         is_access;
    logic [ffsot_pkg::ROW_W-1:0]  busy_rdata;
    logic [ffsot_pkg::PID_W-1:0]  own_rdata;
    logic [ffsot_pkg::ROW_W-1:0]  row_data;
    logic [ffsot_pkg::BIT_AW-1:0] free_bit;
    logic [ffsot_pkg::IDX_W-1:0]  new_slot;
    logic                         res_ok;
    logic                         acc_busy;
    logic                         rel_ok;
    logic [ffsot_pkg::ROW_W-1:0]  row_new;
    logic [ffsot_pkg::CNT_W-1:0]  busy_next;
    logic [ffsot_pkg::STAT_W-1:0] status_next;
    logic [ffsot_pkg::CNT_W-1:0]  given_next;
    logic [ffsot_pkg::PID_W-1:0]  owner_next;
    logic [ffsot_pkg::IDX_W-1:0]  own_waddr;
    logic                         busy_we;
    logic                         own_we;

    assign num_m1     = num_reg - ffsot_pkg::NUM_W'(1);
    assign look_idx   = num_m1[ffsot_pkg::IDX_W-1:0];
    assign is_reserve = (cmd_reg == ffsot_pkg::CMD_RESERVE);
    assign is_access  = (cmd_reg == ffsot_pkg::CMD_RELEASE) || (cmd_reg == ffsot_pkg::CMD_QUERY);

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd;
            pid_reg <= person_id;
            num_reg <= seat_number;
        end
        if (ctl.look)
        begin
            nofree_reg <= &row_full_reg;
            numbad_reg <= (num_reg == '0) ||
                          (num_reg > {{(ffsot_pkg::NUM_W - ffsot_pkg::CNT_W){1'b0}}, used});
            if (is_reserve)
            begin
                row_reg <= ffsot_pkg::first_open_row(row_full_reg);
            end
            else
            begin
                row_reg <= look_idx[ffsot_pkg::IDX_W-1:ffsot_pkg::BIT_AW];
            end
            bit_reg <= look_idx[ffsot_pkg::BIT_AW-1:0];
        end
    end

    ffsot_ram #(
        .WIDTH (ffsot_pkg::ROW_W),
        .DEPTH (ffsot_pkg::ROWS)
    ) u_busy_ram (
        .clk   (clk),
        .we    (busy_we),
        .waddr (row_reg),
        .wdata (row_new),
        .re    (ctl.look),
        .raddr (is_reserve ? ffsot_pkg::first_open_row(row_full_reg)
                           : look_idx[ffsot_pkg::IDX_W-1:ffsot_pkg::BIT_AW]),
        .rdata (busy_rdata)
    );

    ffsot_ram #(
        .WIDTH (ffsot_pkg::PID_W),
        .DEPTH (ffsot_pkg::SLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (pid_reg),
        .re    (ctl.look),
        .raddr (look_idx),
        .rdata (own_rdata)
    );

    always_comb
    begin
        row_data    = row_valid_reg[row_reg] ? busy_rdata : '0;
        free_bit    = ffsot_pkg::first_zero_bit(row_data);
        new_slot    = {row_reg, free_bit};
        res_ok      = is_reserve && (pid_reg != '0) && !nofree_reg &&
                      ({1'b0, new_slot} < used);
        acc_busy    = is_access && !numbad_reg && row_data[bit_reg];
        rel_ok      = acc_busy && (cmd_reg == ffsot_pkg::CMD_RELEASE);
        own_waddr   = new_slot;
        row_new     = row_data;
        busy_next   = busy_total_reg;
        status_next = ffsot_pkg::ST_OK;
        given_next  = '0;
        owner_next  = '0;
        if (res_ok)
        begin
            row_new    = row_data | (ffsot_pkg::ROW_W'(1) << free_bit);
            busy_next  = busy_total_reg + ffsot_pkg::CNT_W'(1);
            given_next = {1'b0, new_slot} + ffsot_pkg::CNT_W'(1);
        end
        else if (is_reserve)
        begin
            status_next = (pid_reg == '0) ? ffsot_pkg::ST_BADID : ffsot_pkg::ST_FULL;
        end
        else if (is_access)
        begin
            if (numbad_reg)
            begin
                status_next = ffsot_pkg::ST_BADNUM;
            end
            else if (!acc_busy)
            begin
                status_next = ffsot_pkg::ST_EMPTY;
            end
            else
            begin
                owner_next = own_rdata;
            end
        end
        if (rel_ok)
        begin
            row_new = row_data & ~(ffsot_pkg::ROW_W'(1) << bit_reg);
            if (busy_total_reg != '0)
            begin
                busy_next = busy_total_reg - ffsot_pkg::CNT_W'(1);
            end
        end
        busy_we = ctl.commit && room_open && (res_ok || rel_ok);
        own_we  = ctl.commit && room_open && res_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            row_full_reg   <= '0;
            busy_total_reg <= '0;
        end
        else if (clr)
        begin
            row_valid_reg  <= '0;
            row_full_reg   <= '0;
            busy_total_reg <= '0;
        end
        else if (busy_we)
        begin
            row_valid_reg[row_reg] <= 1'b1;
            row_full_reg[row_reg]  <= &row_new;
            busy_total_reg         <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            if (room_open)
            begin
                status_reg <= status_next;
                given_reg  <= given_next;
                owner_reg  <= owner_next;
                occ_reg    <= busy_next;
                free_reg   <= (used >= busy_next) ? used - busy_next : '0;
            end
            else
            begin
                status_reg <= ffsot_pkg::ST_CLOSED;
                given_reg  <= '0;
                owner_reg  <= '0;
                occ_reg    <= '0;
                free_reg   <= '0;
            end
        end
    end

    assign status         = status_reg;
    assign seat_given     = given_reg;
    assign owner_id       = owner_reg;
    assign free_count     = free_reg;
    assign occupied_count = occ_reg;

endmodule

// ===== design/first_free_slot_owner_table_top.sv =====
// Top level of the first-free-slot owner table with its configuration registers.
// Each command word is captured, its busy row and owner entry are read, and its result is
// committed to the output register, waiting while an earlier result is still unaccepted.
// The next command word is taken as soon as the previous result sits in the output register.
// Reset, and any configuration write, empties every slot at once through per-row valid bits.
`timescale 1ns / 1ps

module first_free_slot_owner_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ffsot_pkg::CMD_W-1:0]   cmd,
    input  logic [ffsot_pkg::PID_W-1:0]   person_id,
    input  logic [ffsot_pkg::NUM_W-1:0]   seat_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffsot_pkg::STAT_W-1:0]  status,
    output logic [ffsot_pkg::CNT_W-1:0]   seat_given,
    output logic [ffsot_pkg::PID_W-1:0]   owner_id,
    output logic [ffsot_pkg::CNT_W-1:0]   free_count,
    output logic [ffsot_pkg::CNT_W-1:0]   occupied_count
);

    logic                         room_open_reg;
    logic [ffsot_pkg::CNT_W-1:0]  seat_count_reg;
    logic                         cfg_wr;
    logic [ffsot_pkg::CNT_W-1:0]  used;
    ffsot_pkg::ffsot_cmd_t        ctl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign used   = (seat_count_reg > ffsot_pkg::SLOTS_CNT) ? ffsot_pkg::SLOTS_CNT
                                                            : seat_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_open_reg  <= 1'b0;
            seat_count_reg <= ffsot_pkg::SEAT_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ffsot_pkg::REG_ROOM_OPEN)
            begin
                room_open_reg <= pwdata[0];
            end
            else
            begin
                seat_count_reg <= pwdata[ffsot_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == ffsot_pkg::REG_SEAT_COUNT)
        begin
            prdata = {{(32 - ffsot_pkg::CNT_W){1'b0}}, seat_count_reg};
        end
        else
        begin
            prdata = {31'b0, room_open_reg};
        end
    end

    ffsot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    ffsot_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .clr            (cfg_wr),
        .room_open      (room_open_reg),
        .used           (used),
        .cmd            (cmd),
        .person_id      (person_id),
        .seat_number    (seat_number),
        .status         (status),
        .seat_given     (seat_given),
        .owner_id       (owner_id),
        .free_count     (free_count),
        .occupied_count (occupied_count)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted while one is in flight");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ffsot_pkg::ST_CLOSED && !cfg_wr && !$past(cfg_wr))
        |-> (free_count + occupied_count == used))
        else $error("free and occupied counts do not add up to the slots in use");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ffsot_pkg::ST_OK) |-> (seat_given == '0 && owner_id == '0))
        else $error("error result carries a slot number or owner");

    a_reserve_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seat_given != '0) |-> (seat_given <= ffsot_pkg::SLOTS_CNT))
        else $error("granted slot lies beyond the table");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the first-free-slot owner table: scoreboard, drivers and phases.
`timescale 1ns / 1ps

module testbench;
    import ffsot_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;
    localparam logic [2:0]       ADDR_ROOM_OPEN  = 3'd0;
    localparam logic [2:0]       ADDR_SEAT_COUNT = 3'd4;
    localparam logic [PID_W-1:0] MAX_PID         = 31'h7FFF_FFFF;
    localparam int               HOLD_CYCLES     = 80;
    localparam int               DRAIN_CYCLES    = 4;
    localparam int               RANDOM_PHASES   = 13;
    localparam int               WORDS_PER_PHASE = 50;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  seat_given;
        logic [PID_W-1:0]  owner_id;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  occupied_count;
    } slot_result_t;

    class slot_table_scoreboard;
        bit                 room_open;
        bit [CNT_W-1:0]     seat_count;
        bit                 slot_busy[SLOTS];
        bit [PID_W-1:0]     slot_owner[SLOTS];
        int unsigned        busy_total;
        slot_result_t       expected_q[$];
        int                 errors;

        function new();
            room_open  = 1'b0;
            seat_count = SEAT_COUNT_RESET;
            errors     = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_busy[i]  = 1'b0;
                slot_owner[i] = '0;
            end
            busy_total = 0;
        endfunction

        function int unsigned slots_in_use();
            return (seat_count > SLOTS) ? SLOTS : seat_count;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] reg_value(logic [2:0] addr);
            if (addr == ADDR_ROOM_OPEN)
            begin
                return {31'b0, room_open};
            end
            return {21'b0, seat_count};
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] data);
            if (addr == ADDR_ROOM_OPEN)
            begin
                room_open = data[0];
            end
            else if (addr == ADDR_SEAT_COUNT)
            begin
                seat_count = data[CNT_W-1:0];
            end
            clear_table();
        endfunction

        function void note_input(logic [CMD_W-1:0] c, logic [PID_W-1:0] p, logic [NUM_W-1:0] n);
            slot_result_t r;
            int unsigned  used;
            bit           found;
            used  = slots_in_use();
            r     = '0;
            found = 1'b0;
            if (!room_open)
            begin
                r.status = ST_CLOSED;
            end
            else
            begin
                r.status = ST_OK;
                if (c == CMD_RESERVE)
                begin
                    if (p == '0)
                    begin
                        r.status = ST_BADID;
                    end
                    else
                    begin
                        r.status = ST_FULL;
                        for (int i = 0; i < used; i++)
                        begin
                            if (!found && !slot_busy[i])
                            begin
                                found         = 1'b1;
                                slot_busy[i]  = 1'b1;
                                slot_owner[i] = p;
                                busy_total++;
                                r.seat_given  = CNT_W'(i + 1);
                                r.status      = ST_OK;
                            end
                        end
                    end
                end
                else if (c == CMD_RELEASE || c == CMD_QUERY)
                begin
                    if (n == 0 || n > used)
                    begin
                        r.status = ST_BADNUM;
                    end
                    else if (!slot_busy[n - 1])
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        r.owner_id = slot_owner[n - 1];
                        if (c == CMD_RELEASE)
                        begin
                            slot_busy[n - 1] = 1'b0;
                            if (busy_total > 0)
                            begin
                                busy_total--;
                            end
                        end
                    end
                end
                r.free_count     = CNT_W'((used >= busy_total) ? used - busy_total : 0);
                r.occupied_count = CNT_W'(busy_total);
            end
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(slot_result_t got);
            slot_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result word with nothing expected, status",
                                32'(got.status), 32'd0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                begin
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                end
                if (got.seat_given !== want.seat_given)
                begin
                    report_mismatch("seat_given", 32'(got.seat_given), 32'(want.seat_given));
                end
                if (got.owner_id !== want.owner_id)
                begin
                    report_mismatch("owner_id", 32'(got.owner_id), 32'(want.owner_id));
                end
                if (got.free_count !== want.free_count)
                begin
                    report_mismatch("free_count", 32'(got.free_count), 32'(want.free_count));
                end
                if (got.occupied_count !== want.occupied_count)
                begin
                    report_mismatch("occupied_count", 32'(got.occupied_count),
                                    32'(want.occupied_count));
                end
            end
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [CMD_W-1:0]  cmd;
    logic [PID_W-1:0]  person_id;
    logic [NUM_W-1:0]  seat_number;
    logic              out_valid;
    logic              out_ready;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  seat_given;
    logic [PID_W-1:0]  owner_id;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  occupied_count;

    slot_table_scoreboard sb;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;

    first_free_slot_owner_table_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .person_id      (person_id),
        .seat_number    (seat_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .seat_given     (seat_given),
        .owner_id       (owner_id),
        .free_count     (free_count),
        .occupied_count (occupied_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                sb.check_result({status, seat_given, owner_id, free_count, occupied_count});
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    task send_word(logic [CMD_W-1:0] c, logic [PID_W-1:0] p, logic [NUM_W-1:0] n);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        person_id   <= p;
        seat_number <= n;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_input(c, p, n);
    endtask

    task wait_table_idle(int extra);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.write_reg(addr, data);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== sb.reg_value(addr))
        begin
            sb.report_mismatch("register read back", prdata, sb.reg_value(addr));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task configure_table(logic [31:0] open_data, logic [31:0] seat_data);
        wait_table_idle(DRAIN_CYCLES);
        if ($urandom_range(1))
        begin
            apb_write(ADDR_ROOM_OPEN, open_data);
            apb_write(ADDR_SEAT_COUNT, seat_data);
        end
        else
        begin
            apb_write(ADDR_SEAT_COUNT, seat_data);
            apb_write(ADDR_ROOM_OPEN, open_data);
        end
    endtask

    task send_random_word(int reserve_pct);
        logic [CMD_W-1:0] c;
        logic [PID_W-1:0] p;
        int               n;
        int               used;
        int               sel;
        used = sb.slots_in_use();
        sel  = $urandom_range(99);
        p    = PID_W'($urandom());
        n    = $urandom_range(65535);
        if ($urandom_range(15) == 0)
        begin
            p = MAX_PID;
        end
        if (sel < reserve_pct)
        begin
            c = CMD_RESERVE;
            if (p == '0)
            begin
                p = PID_W'(1);
            end
        end
        else if (sel < 90)
        begin
            c = $urandom_range(1) ? CMD_RELEASE : CMD_QUERY;
            n = (used > 0) ? $urandom_range(used, 1) : 0;
        end
        else
        begin
            case ($urandom_range(4))
                0:
                begin
                    c = CMD_RESERVE;
                    p = '0;
                end
                1:
                begin
                    c = $urandom_range(1) ? CMD_RELEASE : CMD_QUERY;
                    n = 0;
                end
                2:
                begin
                    c = $urandom_range(1) ? CMD_RELEASE : CMD_QUERY;
                    n = used + 1 + $urandom_range(3);
                end
                3:
                begin
                    c = CMD_W'($urandom_range(3));
                end
                default:
                begin
                    c = CMD_UNUSED;
                end
            endcase
        end
        send_word(c, p, NUM_W'(n));
    endtask

    initial
    begin
        int seat_value;
        int reserve_pct;
        logic [31:0] open_data;
        logic [31:0] seat_data;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        cmd         <= '0;
        person_id   <= '0;
        seat_number <= '0;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // The table comes out of reset closed, with every slot in use.
        send_word(CMD_RESERVE, 31'd7, 16'd0);
        send_word(CMD_UNUSED, 31'd7, 16'd1);

        wait_table_idle(DRAIN_CYCLES);
        apb_write(ADDR_ROOM_OPEN, 32'd1);
        send_word(CMD_RESERVE, MAX_PID, 16'd0);
        send_word(CMD_RESERVE, 31'd0, 16'd0);
        send_word(CMD_QUERY, 31'd0, 16'd1);
        send_word(CMD_QUERY, 31'd0, 16'd0);
        send_word(CMD_QUERY, 31'd0, 16'd1025);
        send_word(CMD_RELEASE, 31'd0, 16'hFFFF);
        send_word(CMD_QUERY, 31'd0, 16'd2);
        send_word(CMD_RELEASE, 31'd0, 16'd1);
        send_word(CMD_RELEASE, 31'd0, 16'd1);
        send_word(CMD_UNUSED, MAX_PID, 16'hFFFF);
        send_word(CMD_RESERVE, 31'd1, 16'd0);

        configure_table(32'd1, 32'd1);
        send_word(CMD_RESERVE, 31'd5, 16'd0);
        send_word(CMD_RESERVE, 31'd6, 16'd0);
        send_word(CMD_QUERY, 31'd0, 16'd1);
        send_word(CMD_RELEASE, 31'd0, 16'd1);

        configure_table(32'd1, 32'd0);
        send_word(CMD_RESERVE, 31'd9, 16'd0);
        send_word(CMD_QUERY, 31'd0, 16'd1);
        send_word(CMD_RELEASE, 31'd0, 16'd0);

        configure_table(32'd1, 32'd2047);
        send_word(CMD_RESERVE, 31'd3, 16'd0);
        send_word(CMD_QUERY, 31'd0, 16'd1024);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       seat_value = 1;
                1:       seat_value = 1024;
                2:       seat_value = 2;
                3:       seat_value = 2047;
                4:       seat_value = 0;
                7:       seat_value = $urandom_range(2047);
                default: seat_value = $urandom_range(24, 1);
            endcase
            open_data = (ph == 5) ? 32'd0 : 32'd1;
            seat_data = 32'(seat_value);
            if (ph % 2 == 1)
            begin
                open_data = ($urandom() & ~32'd1) | open_data;
                seat_data = ($urandom() & ~32'h7FF) | seat_data;
            end
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
            configure_table(open_data, seat_data);
            case (ph % 4)
                1:
                begin
                    sender_idle_pct = 82;
                end
                2:
                begin
                    receiver_stall_pct = 82;
                end
                3:
                begin
                    sender_idle_pct    = 15;
                    receiver_stall_pct = 15;
                end
                default:
                begin
                end
            endcase
            reserve_pct = (ph == 1) ? 70 : $urandom_range(70, 30);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                if (ph == 0 && k == 10)
                begin
                    hold_requests++;
                end
                if (ph == 6 && k == WORDS_PER_PHASE / 2)
                begin
                    wait_table_idle(1);
                end
                send_random_word(reserve_pct);
            end
        end

        wait_table_idle(10);
        if (sb.errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
